>>> rtl/core/emboss_convolution_3x3_rgb_macros.svh
// Assertion macros for the emboss filter. Each check samples on clk and is
// disabled while rst is high.
`ifndef EMBOSS_CONVOLUTION_3X3_RGB_MACROS_SVH
`define EMBOSS_CONVOLUTION_3X3_RGB_MACROS_SVH
`ifndef SYNTHESIS
`define ECV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecv check failed");
`define ECV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecv check failed");
`else
`define ECV_ASSERT_NOW(lbl, ante, cons)
`define ECV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/ecv_pkg.sv
package ecv_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int TAP_W   = 5;
  localparam int SIZE_W  = 12;
  localparam int KERN_W  = 45;
  localparam int BIAS_W  = 9;
  localparam int OWED_W  = 13;
  localparam int PSUM_W  = 15;
  localparam int SUM_W   = 17;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [KERN_W-1:0] KERN_RST   = 45'd1133905937407;
  localparam logic [BIAS_W-1:0] BIAS_RST   = 9'd128;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2,
    REG_BIAS   = 2'd3
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][PIX_W-1:0] col_t;
  typedef logic [2:0][TAP_W-1:0] tap_col_t;
  typedef logic signed [PSUM_W-1:0] psum_t;

  typedef struct packed {
    logic take;
    logic retire;
  } lb_ctrl_t;

  typedef struct packed {
    logic advance;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            fend;
  } result_t;

  function automatic tap_col_t tap_col(input logic [KERN_W-1:0] kern, input int col);
    tap_col_t t;
    for (int r = 0; r < 3; r++) begin
      t[r] = kern[TAP_W*(3*r+col) +: TAP_W];
    end
    return t;
  endfunction

  function automatic logic [CH_W-1:0] clamp8(input logic signed [SUM_W-1:0] s);
    logic [CH_W-1:0] v;
    if (s < 0) begin
      v = '0;
    end else if (s > SUM_W'(255)) begin
      v = 8'hFF;
    end else begin
      v = s[CH_W-1:0];
    end
    return v;
  endfunction

endpackage

>>> rtl/core/ecv_line_buf.sv
module ecv_line_buf #(
  parameter int MAX_WIDTH = ecv_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ecv_pkg::lb_ctrl_t            ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  ecv_pkg::pix_t                pix,
  output ecv_pkg::pix_t                top,
  output ecv_pkg::pix_t                mid
);
  import ecv_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  pix_t          mem_mid [MAX_WIDTH];
  pix_t          mem_top [MAX_WIDTH];
  pix_t          rd_mid;
  pix_t          rd_top;
  pix_t          prev_mid;
  logic [AW-1:0] addr_q;
  logic          fwd;

  // Newest row goes straight in; the older row is written back later, from the registered read, when the entry retires.
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      rd_mid        <= mem_mid[addr];
      rd_top        <= mem_top[addr];
      mem_mid[addr] <= pix;
      addr_q        <= addr;
    end
    if (ctrl.retire) begin
      mem_top[addr_q] <= rd_mid;
      prev_mid        <= rd_mid;
    end
  end

  // Catch a read of the entry being written back in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (ctrl.take) begin
      fwd <= ctrl.retire && (addr_q == addr);
    end
  end

  assign mid = rd_mid;
  assign top = fwd ? prev_mid : rd_top;

endmodule

>>> rtl/core/ecv_cell.sv
module ecv_cell (
  input  logic                clk,
  input  logic                rst,
  input  ecv_pkg::cell_ctrl_t ctrl,
  input  ecv_pkg::col_t       col_in,
  input  ecv_pkg::tap_col_t   taps,
  output ecv_pkg::col_t       col_out,
  output ecv_pkg::psum_t      psum [3]
);
  import ecv_pkg::*;

  col_t  col_q;
  psum_t psum_d [3];
  psum_t psum_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (ctrl.shift) begin
      col_q <= col_in;
    end
  end

  // One column of the window, three taps per channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      psum_d[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        psum_d[ch] = psum_d[ch]
                   + psum_t'($signed({1'b0, col_q[r][CH_W*ch +: CH_W]}))
                   * psum_t'($signed(taps[r]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      psum_q <= psum_d;
    end
  end

  assign col_out = col_q;
  assign psum    = psum_q;

endmodule

>>> rtl/core/emboss_convolution_3x3_rgb.sv
// 3x3 emboss filter on a BGR raster stream: one pixel (or flush tick) is taken
// per clock while in_stall is low, and each channel gets the nine configured
// 5-bit signed taps, the bias and a clamp to 0..255, while the outer rows and
// columns pass through. A result belongs to the pixel one row plus one pixel
// earlier, so a frame gives its first result after w_eff+1 items and needs
// that many flush ticks at its end; frame_end marks the last result, after
// which counters restart. Each result passes through the line buffer read,
// the window shift through the column cells, the per-column products and the
// final sum and clamp. Two line buffer memories of MAX_WIDTH pixels hold the
// previous rows; they need no clearing after reset. A stalled result parks in
// a skid register, and in_stall rises only while it is full.
`include "emboss_convolution_3x3_rgb_macros.svh"
module emboss_convolution_3x3_rgb #(
  parameter int MAX_WIDTH = ecv_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecv_pkg::PADDR_W-1:0] paddr,
  input  logic [ecv_pkg::PDATA_W-1:0] pwdata,
  output logic [ecv_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [ecv_pkg::CH_W-1:0]    in_blue,
  input  logic [ecv_pkg::CH_W-1:0]    in_green,
  input  logic [ecv_pkg::CH_W-1:0]    in_red,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ecv_pkg::CH_W-1:0]    out_blue,
  output logic [ecv_pkg::CH_W-1:0]    out_green,
  output logic [ecv_pkg::CH_W-1:0]    out_red,
  output logic                        frame_end
);
  import ecv_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [KERN_W-1:0] kernel_coefficients;
  logic [BIAS_W-1:0] bias_offset;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width         <= WIDTH_RST;
      image_height        <= HEIGHT_RST;
      kernel_coefficients <= KERN_RST;
      bias_offset         <= BIAS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH:  image_width         <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: image_height        <= pwdata[SIZE_W-1:0];
        REG_KERNEL: kernel_coefficients <= pwdata[KERN_W-1:0];
        REG_BIAS:   bias_offset         <= pwdata[BIAS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      REG_KERNEL: prdata = PDATA_W'(kernel_coefficients);
      REG_BIAS:   prdata = PDATA_W'(bias_offset);
      default:    prdata = '0;
    endcase
  end

  // effective frame size
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = 12'd1;
    end else if ({2'b00, image_width} > 14'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = 12'd1;
    end else if ({2'b00, image_height} > 14'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // position tracking at the input
  logic [SIZE_W-1:0] column_count, column_count_next;
  logic [SIZE_W-1:0] row_count, row_count_next;
  logic [OWED_W-1:0] owed_results, owed_results_next;
  logic [SIZE_W-1:0] c_cur;
  logic              adv;
  logic              act;
  logic              emit;
  logic              fend;
  logic              border;
  pix_t              pix;

  logic skid_valid;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;
  // drop a flush tick when nothing is owed
  assign act      = in_valid && !in_stall && !(mode && (owed_results == '0));
  assign c_cur    = (column_count >= w_eff) ? '0 : column_count;
  assign emit     = owed_results >= ({1'b0, w_eff} + 13'd1);
  assign fend     = emit && ({1'b0, row_count} >= ({1'b0, h_eff} + 13'd1))
                    && (c_cur == '0);
  assign border   = (c_cur == '0) || (c_cur == 12'd1) || (row_count <= 12'd1)
                    || (row_count >= h_eff);
  assign pix      = mode ? '0 : {in_red, in_green, in_blue};

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    owed_results_next = owed_results;
    if (act) begin
      if (fend) begin
        column_count_next = '0;
        row_count_next    = '0;
        owed_results_next = '0;
      end else begin
        if (!emit) begin
          owed_results_next = owed_results + 13'd1;
        end
        if (({1'b0, c_cur} + 13'd1) >= {1'b0, w_eff}) begin
          column_count_next = '0;
          row_count_next    = row_count + 12'd1;
        end else begin
          column_count_next = c_cur + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      owed_results <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      owed_results <= owed_results_next;
    end
  end

  // stage 1: line buffer read
  logic s1_valid, s1_emit, s1_fend, s1_border;
  pix_t s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_emit   <= emit;
      s1_fend   <= fend;
      s1_border <= border;
      s1_pix    <= pix;
    end
  end

  lb_ctrl_t lb_ctrl;
  pix_t     top_pix;
  pix_t     mid_pix;

  assign lb_ctrl.take   = act;
  assign lb_ctrl.retire = adv && s1_valid;

  ecv_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk (clk),
    .rst (rst),
    .ctrl(lb_ctrl),
    .addr(AW'(c_cur)),
    .pix (pix),
    .top (top_pix),
    .mid (mid_pix)
  );

  // stage 2: window shift through the column cells
  cell_ctrl_t cell_ctrl;
  col_t       col_new;
  col_t       col_2;
  col_t       col_1;
  psum_t      ps0 [3];
  psum_t      ps1 [3];
  psum_t      ps2 [3];

  assign cell_ctrl.advance = adv;
  assign cell_ctrl.shift   = adv && s1_valid;
  assign col_new[0]        = top_pix;
  assign col_new[1]        = mid_pix;
  assign col_new[2]        = s1_pix;

  ecv_cell u_cell2 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (cell_ctrl),
    .col_in (col_new),
    .taps   (tap_col(kernel_coefficients, 2)),
    .col_out(col_2),
    .psum   (ps2)
  );

  ecv_cell u_cell1 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (cell_ctrl),
    .col_in (col_2),
    .taps   (tap_col(kernel_coefficients, 1)),
    .col_out(col_1),
    .psum   (ps1)
  );

  ecv_cell u_cell0 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (cell_ctrl),
    .col_in (col_1),
    .taps   (tap_col(kernel_coefficients, 0)),
    .col_out(),
    .psum   (ps0)
  );

  logic s2_valid, s2_fend, s2_border;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_fend   <= s1_fend;
      s2_border <= s1_border;
    end
  end

  // stage 3: column products registered in the cells, sum and clamp here
  logic s3_valid, s3_fend, s3_border;
  pix_t s3_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fend   <= s2_fend;
      s3_border <= s2_border;
      s3_ctr    <= col_1[1];
    end
  end

  logic signed [BIAS_W-1:0] bias_s;
  logic signed [SUM_W-1:0]  sum [3];
  logic [CH_W-1:0]          chan [3];
  result_t                  res;

  assign bias_s = signed'(bias_offset);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch]  = SUM_W'(ps0[ch]) + SUM_W'(ps1[ch]) + SUM_W'(ps2[ch]) + SUM_W'(bias_s);
      chan[ch] = s3_border ? s3_ctr[CH_W*ch +: CH_W] : clamp8(sum[ch]);
    end
  end

  assign res.blue  = chan[0];
  assign res.green = chan[1];
  assign res.red   = chan[2];
  assign res.fend  = s3_fend;

  // output register with skid
  result_t out_q;
  result_t skid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (s3_valid) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_q <= skid_q;
      end
    end else if (s3_valid) begin
      if (out_valid && out_stall) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_blue  = out_q.blue;
  assign out_green = out_q.green;
  assign out_red   = out_q.red;
  assign frame_end = out_q.fend;

  `ECV_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `ECV_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid && out_valid)
  `ECV_ASSERT_NEXT(a_frame_restart, act && fend, {row_count, column_count, owed_results} == '0)

endmodule

>>> tb/sv/emboss_convolution_3x3_rgb_test.sv
module emboss_convolution_3x3_rgb_test;
  import ecv_pkg::*;

  localparam int MAX_W           = MAX_WIDTH_DEF;
  localparam int MAX_H           = MAX_HEIGHT;
  localparam int REG_STRIDE      = 8;
  localparam logic MODE_PIXEL    = 1'b0;
  localparam logic MODE_FLUSH    = 1'b1;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_ITEMS    = 1250;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 12;
  localparam int MAX_PRINTS      = 50;

  localparam logic [KERN_W-1:0] KERN_MAX_POS = {9{5'h0F}};
  localparam logic [KERN_W-1:0] KERN_MAX_NEG = {9{5'h10}};
  localparam logic [BIAS_W-1:0] BIAS_MIN     = 9'h100;
  localparam logic [BIAS_W-1:0] BIAS_MAX     = 9'h0FF;

  typedef struct {
    logic            mode;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_item_t;

  typedef struct {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            frame_end;
  } filtered_px_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = MODE_PIXEL;
  logic [CH_W-1:0]    in_blue = '0;
  logic [CH_W-1:0]    in_green = '0;
  logic [CH_W-1:0]    in_red = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CH_W-1:0]    out_blue;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_red;
  logic               frame_end;

  emboss_convolution_3x3_rgb i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .frame_end (frame_end)
  );

  // shadow registers and filter state
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [KERN_W-1:0] kernel_reg;
  logic [BIAS_W-1:0] bias_reg;
  pix_t              line_buf [2*MAX_W];
  pix_t              win [3][3];
  int                col_pos;
  int                row_pos;
  int                owed;

  pixel_item_t  pending_pixels[$];
  filtered_px_t expected_pixels[$];
  pixel_item_t  next_item;
  filtered_px_t want_px;
  int           error_cnt = 0;
  int           result_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clamp_size(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] filter_channel(int shift);
    int                       acc;
    int                       tap;
    logic signed [TAP_W-1:0]  tap5;
    logic signed [BIAS_W-1:0] bias9;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap5 = kernel_reg[TAP_W*(3*r+c) +: TAP_W];
        tap = tap5;
        acc += int'(win[r][c][shift +: CH_W]) * tap;
      end
    end
    bias9 = bias_reg;
    acc += int'(bias9);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[CH_W-1:0];
  endfunction

  task automatic emboss_predict(logic item_mode, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                                logic [CH_W-1:0] r);
    int           w;
    int           h;
    int           c;
    int           orow;
    int           ocol;
    pix_t         pix;
    pix_t         top;
    pix_t         mid;
    pix_t         ctr;
    logic         on_border;
    logic         fend;
    filtered_px_t res;
    w = clamp_size(int'(width_reg), MAX_W);
    h = clamp_size(int'(height_reg), MAX_H);
    if (item_mode == MODE_FLUSH && owed == 0) return;
    pix = (item_mode == MODE_FLUSH) ? '0 : {r, g, b};
    c = col_pos;
    if (c >= w) c = 0;
    top = line_buf[MAX_W + c];
    mid = line_buf[c];
    line_buf[MAX_W + c] = mid;
    line_buf[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (owed >= w + 1) begin
      ctr = win[1][1];
      if (c == 0) begin
        ocol = w - 1;
        orow = row_pos - 2;
      end else begin
        ocol = c - 1;
        orow = row_pos - 1;
      end
      on_border = orow <= 0 || orow >= h - 1 || ocol <= 0 || ocol >= w - 1;
      if (on_border) begin
        res.blue  = ctr[7:0];
        res.green = ctr[15:8];
        res.red   = ctr[23:16];
      end else begin
        res.blue  = filter_channel(0);
        res.green = filter_channel(8);
        res.red   = filter_channel(16);
      end
      fend = (row_pos >= h + 1) && (c == 0);
      res.frame_end = fend;
      expected_pixels.push_back(res);
      if (fend) begin
        col_pos = 0;
        row_pos = 0;
        owed = 0;
        return;
      end
    end else begin
      owed = (owed + 1) & 'h1FFF;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 'hFFF;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                result_cnt, name, got, want));
  endtask

  // input driver: advance on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) emboss_predict(mode, in_blue, in_green, in_red);
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_pixels.pop_front();
          in_valid <= 1'b1;
          mode     <= next_item.mode;
          in_blue  <= next_item.blue;
          in_green <= next_item.green;
          in_red   <= next_item.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_OFF_CYCLES;
      hold_served <= hold_requests;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no pixel owed", result_cnt));
      end else begin
        want_px = expected_pixels.pop_front();
        check_field("out_blue", out_blue, want_px.blue);
        check_field("out_green", out_green, want_px.green);
        check_field("out_red", out_red, want_px.red);
        check_field("frame_end", frame_end, want_px.frame_end);
      end
      result_cnt++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic cfg_write(cfg_reg_t idx, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_STRIDE * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_reg = val[SIZE_W-1:0];
        want      = PDATA_W'(val[SIZE_W-1:0]);
      end
      REG_HEIGHT: begin
        height_reg = val[SIZE_W-1:0];
        want       = PDATA_W'(val[SIZE_W-1:0]);
      end
      REG_KERNEL: begin
        kernel_reg = val[KERN_W-1:0];
        want       = PDATA_W'(val[KERN_W-1:0]);
      end
      REG_BIAS: begin
        bias_reg = val[BIAS_W-1:0];
        want     = PDATA_W'(val[BIAS_W-1:0]);
      end
      default: want = '0;
    endcase
    // read the register back once the write has landed
    @(negedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read back %0h expected %0h",
                                idx, prdata, want));
  endtask

  task automatic program_config(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                                logic [KERN_W-1:0] k, logic [BIAS_W-1:0] b);
    cfg_write(REG_WIDTH, PDATA_W'(w));
    cfg_write(REG_HEIGHT, PDATA_W'(h));
    cfg_write(REG_KERNEL, PDATA_W'(k));
    cfg_write(REG_BIAS, PDATA_W'(b));
  endtask

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_item(logic m);
    pixel_item_t it;
    it.mode  = m;
    it.blue  = rand_chan();
    it.green = rand_chan();
    it.red   = rand_chan();
    pending_pixels.push_back(it);
  endfunction

  function automatic void queue_rgb(logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                                    logic [CH_W-1:0] r);
    pixel_item_t it;
    it.mode  = MODE_PIXEL;
    it.blue  = b;
    it.green = g;
    it.red   = r;
    pending_pixels.push_back(it);
  endfunction

  // one frame plus its tail, with a little noise; returns the transaction count, not counting a leading flush tick
  function automatic int queue_frame(int w, int h);
    int n;
    n = 0;
    if ($urandom_range(0, 7) == 0) queue_item(MODE_FLUSH);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 63) == 0) begin
        queue_item(MODE_FLUSH);
        n++;
      end
      queue_item(MODE_PIXEL);
      n++;
    end
    for (int i = 0; i <= w; i++) begin
      queue_item(($urandom_range(0, 7) == 0) ? MODE_PIXEL : MODE_FLUSH);
      n++;
    end
    return n;
  endfunction

  task automatic wait_accepted();
    do @(negedge clk); while (pending_pixels.size() != 0 || in_valid);
  endtask

  // finish the frame in flight and wait for every owed result
  task automatic drain_phase();
    wait_accepted();
    while (owed != 0) begin
      queue_item(MODE_FLUSH);
      wait_accepted();
    end
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                random_items;
    int                stage;
    int                frames;
    logic [SIZE_W-1:0] w_cfg;
    logic [SIZE_W-1:0] h_cfg;
    logic [KERN_W-1:0] k_cfg;
    logic [BIAS_W-1:0] b_cfg;
    logic              hold_issued;

    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    kernel_reg = KERN_RST;
    bias_reg   = BIAS_RST;
    for (int i = 0; i < 2 * MAX_W; i++) line_buf[i] = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    random_items = 0;
    hold_issued = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 68;

    // 3x3 frame, most negative taps: interior clamps low, flush with nothing owed
    program_config(12'd3, 12'd3, KERN_MAX_NEG, BIAS_MAX);
    queue_item(MODE_FLUSH);
    queue_rgb(8'h00, 8'h00, 8'h00);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'h00, 8'hFF, 8'h00);
    queue_rgb(8'hFF, 8'h00, 8'hFF);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'h00, 8'h00, 8'h00);
    queue_rgb(8'h80, 8'h7F, 8'h01);
    queue_rgb(8'hFF, 8'h00, 8'h00);
    queue_rgb(8'h00, 8'h00, 8'hFF);
    queue_item(MODE_FLUSH);
    queue_item(MODE_FLUSH);
    queue_item(MODE_FLUSH);
    queue_item(MODE_PIXEL);
    queue_item(MODE_FLUSH);
    drain_phase();

    // zero sizes clamp to one pixel; padding pixel closes the frame
    program_config(12'd0, 12'd0, KERN_MAX_POS, BIAS_MIN);
    queue_rgb(8'hFF, 8'h00, 8'hFF);
    queue_item(MODE_FLUSH);
    queue_item(MODE_PIXEL);
    drain_phase();

    while (random_items < RANDOM_ITEMS) begin
      stage = random_items * 3 / RANDOM_ITEMS;
      case (stage)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case ($urandom_range(0, 9))
        0: w_cfg = 12'd0;
        1: w_cfg = 12'd3;
        default: w_cfg = SIZE_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0: h_cfg = 12'd0;
        1: h_cfg = 12'd3;
        default: h_cfg = SIZE_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 4))
        0: k_cfg = KERN_RST;
        1: k_cfg = KERN_MAX_POS;
        2: k_cfg = KERN_MAX_NEG;
        3: k_cfg = '0;
        default: k_cfg = KERN_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 4))
        0: b_cfg = BIAS_MIN;
        1: b_cfg = BIAS_MAX;
        2: b_cfg = '0;
        3: b_cfg = BIAS_RST;
        default: b_cfg = BIAS_W'($urandom);
      endcase
      frames = $urandom_range(1, 3);
      if (stage >= 2 && !hold_issued) begin
        w_cfg = 12'd10;
        h_cfg = 12'd10;
        frames = 2;
      end
      program_config(w_cfg, h_cfg, k_cfg, b_cfg);
      if (stage >= 2 && !hold_issued) begin
        // stall the output while the sender keeps offering pixels
        hold_requests++;
        hold_issued = 1'b1;
      end
      for (int f = 0; f < frames; f++)
        random_items += queue_frame(clamp_size(int'(w_cfg), MAX_W),
                                    clamp_size(int'(h_cfg), MAX_H));
      drain_phase();
    end

    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ecv_pkg.sv
rtl/core/ecv_line_buf.sv
rtl/core/ecv_cell.sv
rtl/core/emboss_convolution_3x3_rgb.sv
tb/sv/emboss_convolution_3x3_rgb_test.sv
